### rtl/core/simple_linear_regression_fit_macros.svh
// Assertion macros for the simple linear regression fit block.
// Included by the top level only; expands to nothing under SYNTHESIS.
`ifndef SIMPLE_LINEAR_REGRESSION_FIT_MACROS_SVH
`define SIMPLE_LINEAR_REGRESSION_FIT_MACROS_SVH
`ifndef SYNTHESIS
`define SLRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SLRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SLRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/core/slrf_pkg.sv
// Shared types and constants of the simple linear regression fit block.
// No dependencies.
package slrf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SUM_X_W     = 29;
  localparam int SUM_XX_W    = 43;
  localparam int SUM_XY_W    = 44;
  localparam int COUNT_W     = 13;
  localparam int MAX_SAMPLES = 4096;
  localparam int Q_W         = 32;
  localparam int ARG_W       = 64;
  localparam int PROD_W      = 128;
  localparam int DEN_W       = 80;
  localparam int NUM_W       = PROD_W + 32;
  localparam int CNT_W       = 8;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = 1;
  localparam int FIFO_CNT_W  = 2;

  localparam logic [Q_W-1:0] NV_RESET = 32'h0001_0000;

  typedef struct packed {
    logic [COUNT_W-1:0]  n;
    logic [SUM_X_W-1:0]  sx;
    logic [SUM_X_W-1:0]  sy;
    logic [SUM_XX_W-1:0] sxx;
    logic [SUM_XY_W-1:0] sxy;
    logic [SUM_XX_W-1:0] syy;
  } sums_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_e;

  typedef struct packed {
    logic              start;
    arith_op_e         op;
    logic              frac32;
    logic              rnd;
    logic [ARG_W-1:0]  opa;
    logic [ARG_W-1:0]  opb;
    logic [PROD_W-1:0] num;
    logic [DEN_W-1:0]  den;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] res;
  } arith_rsp_t;

  typedef struct packed {
    logic [Q_W-1:0] intercept;
    logic [Q_W-1:0] slope;
    logic [Q_W-1:0] intercept_stderr;
    logic [Q_W-1:0] slope_stderr;
    logic [Q_W-1:0] residual_sigma;
    logic           fit_valid;
  } fit_t;

endpackage

### rtl/core/simple_linear_regression_fit.sv
// Simple linear regression fit: samples are summed at one per cycle while full is low;
// the fit of a column runs on one shared serial multiply/divide/root unit
// (15 multiplies, 5 divides, 3 roots).
// A two-entry column queue lets sampling go on while a fit runs; full rises only
// when two finished columns wait. Reset clears all sums and sets noise_variance to 1.0.
module simple_linear_regression_fit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [15:0]            x_sample_i,
  input  logic signed [15:0]            y_sample_i,
  input  logic                          last_sample_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [31:0]            intercept_o,
  output logic signed [31:0]            slope_o,
  output logic [31:0]                   intercept_stderr_o,
  output logic [31:0]                   slope_stderr_o,
  output logic [31:0]                   residual_sigma_o,
  output logic                          fit_valid_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [31:0]                   cfg_data_i
);

`include "simple_linear_regression_fit_macros.svh"

  logic [slrf_pkg::Q_W-1:0] noise_variance_q;
  logic                     accept;
  logic                     fifo_push, fifo_full, fifo_pop, fifo_empty;
  slrf_pkg::sums_t          fifo_wdata, fifo_rdata;
  slrf_pkg::arith_req_t     arith_req;
  slrf_pkg::arith_rsp_t     arith_rsp;
  slrf_pkg::fit_t           fit;

  assign accept      = push && !full;
  assign full        = fifo_full;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_variance_q <= slrf_pkg::NV_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      noise_variance_q <= cfg_data_i;
    end
  end

  slrf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .x_sample_i    (x_sample_i),
    .y_sample_i    (y_sample_i),
    .last_sample_i (last_sample_i),
    .push_o        (fifo_push),
    .sums_o        (fifo_wdata)
  );

  slrf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (fifo_wdata),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .data_o  (fifo_rdata)
  );

  slrf_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .rsp_o  (arith_rsp)
  );

  slrf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .noise_variance_i (noise_variance_q),
    .fifo_empty_i     (fifo_empty),
    .fifo_data_i      (fifo_rdata),
    .fifo_pop_o       (fifo_pop),
    .arith_req_o      (arith_req),
    .arith_rsp_i      (arith_rsp),
    .pop_i            (pop),
    .empty_o          (empty),
    .fit_o            (fit)
  );

  assign intercept_o        = fit.intercept;
  assign slope_o            = fit.slope;
  assign intercept_stderr_o = fit.intercept_stderr;
  assign slope_stderr_o     = fit.slope_stderr;
  assign residual_sigma_o   = fit.residual_sigma;
  assign fit_valid_o        = fit.fit_valid;

  `SLRF_ASSERT_IMP(a_fifo_no_overflow, clk_i, rst_ni, fifo_push, !fifo_full, "column queue overflow")
  `SLRF_ASSERT_IMP(a_fifo_no_underflow, clk_i, rst_ni, fifo_pop, !fifo_empty, "column queue underflow")
  `SLRF_ASSERT_NXT(a_fifo_fill, clk_i, rst_ni, fifo_push && fifo_empty, !fifo_empty, "column lost")
  `SLRF_ASSERT_IMP(a_unfit_zero, clk_i, rst_ni, !empty && !fit_valid_o, (slope_o == '0) && (intercept_o == '0) && (residual_sigma_o == '0), "invalid fit not zeroed")

endmodule

### rtl/core/slrf_front.sv
// Front end: accumulates running sums of one column, one sample per accepted cycle.
// Depends on slrf_pkg; hands finished column sums to slrf_fifo.
module slrf_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [slrf_pkg::SAMPLE_W-1:0]  x_sample_i,
  input  logic [slrf_pkg::SAMPLE_W-1:0]  y_sample_i,
  input  logic                           last_sample_i,
  output logic                           push_o,
  output slrf_pkg::sums_t                sums_o
);

  localparam int PW = 2 * slrf_pkg::SAMPLE_W;

  slrf_pkg::sums_t sums_q, sums_d;
  logic signed [slrf_pkg::SAMPLE_W-1:0] x, y;
  logic signed [PW-1:0] pxx, pxy, pyy;
  logic room;

  assign x    = x_sample_i;
  assign y    = y_sample_i;
  assign pxx  = x * x;
  assign pxy  = x * y;
  assign pyy  = y * y;
  assign room = sums_q.n < slrf_pkg::COUNT_W'(slrf_pkg::MAX_SAMPLES);

  always_comb begin
    sums_d = sums_q;
    if (room) begin
      sums_d.n   = sums_q.n + slrf_pkg::COUNT_W'(1);
      sums_d.sx  = sums_q.sx
                 + {{(slrf_pkg::SUM_X_W-slrf_pkg::SAMPLE_W){x[slrf_pkg::SAMPLE_W-1]}}, x};
      sums_d.sy  = sums_q.sy
                 + {{(slrf_pkg::SUM_X_W-slrf_pkg::SAMPLE_W){y[slrf_pkg::SAMPLE_W-1]}}, y};
      sums_d.sxx = sums_q.sxx + slrf_pkg::SUM_XX_W'(unsigned'(pxx));
      sums_d.syy = sums_q.syy + slrf_pkg::SUM_XX_W'(unsigned'(pyy));
      sums_d.sxy = sums_q.sxy + {{(slrf_pkg::SUM_XY_W-PW){pxy[PW-1]}}, pxy};
    end
  end

  assign push_o = accept_i && last_sample_i;
  assign sums_o = sums_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '0;
    end else if (accept_i) begin
      if (last_sample_i) begin
        sums_q <= '0;
      end else begin
        sums_q <= sums_d;
      end
    end
  end

endmodule

### rtl/core/slrf_fifo.sv
// Short queue of finished column sums between front and back end.
// Depends on slrf_pkg.
module slrf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  slrf_pkg::sums_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output slrf_pkg::sums_t data_o
);

  slrf_pkg::sums_t mem_q [slrf_pkg::FIFO_DEPTH];
  logic [slrf_pkg::FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [slrf_pkg::FIFO_CNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = cnt_q == slrf_pkg::FIFO_CNT_W'(slrf_pkg::FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + slrf_pkg::FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + slrf_pkg::FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + slrf_pkg::FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - slrf_pkg::FIFO_CNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/slrf_arith.sv
// Shared serial arithmetic unit: shift-add multiply, restoring divide, bitwise root.
// Depends on slrf_pkg; driven by slrf_back.
module slrf_arith (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slrf_pkg::arith_req_t req_i,
  output slrf_pkg::arith_rsp_t rsp_o
);

  localparam int AW = slrf_pkg::ARG_W;
  localparam int PW = slrf_pkg::PROD_W;
  localparam int DW = slrf_pkg::DEN_W;
  localparam int NW = slrf_pkg::NUM_W;
  localparam int CW = slrf_pkg::CNT_W;
  localparam logic [CW-1:0] MUL_LAST  = CW'(AW - 1);
  localparam logic [CW-1:0] DIV_LAST  = CW'(NW - 1);
  localparam logic [CW-1:0] SQRT_LAST = CW'(AW / 2 - 1);

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_SQRT,
    A_FIN
  } state_e;

  state_e              state_q;
  slrf_pkg::arith_op_e op_q;
  logic [CW-1:0]       cnt_q;
  logic [PW-1:0]       acc_q, mcand_q;
  logic [AW-1:0]       mplier_q;
  logic                neg_q;
  logic [NW-1:0]       numsh_q;
  logic [DW-1:0]       den_q, rem_q;
  logic [AW-1:0]       quo_q;
  logic                sat_q, rnd_q;
  logic [AW-1:0]       v_q, root_q, bit_q;
  logic                done_q;
  logic [PW-1:0]       res_q;

  logic [AW-1:0] opa_mag, opb_mag, sq_t;
  logic [DW:0]   rem_sh, rem_sub;
  logic          ge, sq_ge, rup;
  logic [AW:0]   qsum;
  logic [PW-1:0] fin_res;

  assign opa_mag = req_i.opa[AW-1] ? -req_i.opa : req_i.opa;
  assign opb_mag = req_i.opb[AW-1] ? -req_i.opb : req_i.opb;
  assign rem_sh  = {rem_q, numsh_q[NW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign sq_t    = root_q + bit_q;
  assign sq_ge   = v_q >= sq_t;
  assign rup     = rnd_q && ({rem_q, 1'b0} >= {1'b0, den_q});
  assign qsum    = {1'b0, quo_q} + (AW+1)'(rup);

  always_comb begin
    unique case (op_q)
      slrf_pkg::OP_MUL:  fin_res = neg_q ? -acc_q : acc_q;
      slrf_pkg::OP_DIV:  fin_res = (sat_q || qsum[AW]) ? PW'({AW{1'b1}}) : PW'(qsum[AW-1:0]);
      slrf_pkg::OP_SQRT: fin_res = PW'(root_q[AW/2-1:0]);
      default:           fin_res = '0;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= A_IDLE;
      op_q     <= slrf_pkg::OP_MUL;
      cnt_q    <= '0;
      acc_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
      neg_q    <= 1'b0;
      numsh_q  <= '0;
      den_q    <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      sat_q    <= 1'b0;
      rnd_q    <= 1'b0;
      v_q      <= '0;
      root_q   <= '0;
      bit_q    <= '0;
      done_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            op_q  <= req_i.op;
            cnt_q <= '0;
            unique case (req_i.op)
              slrf_pkg::OP_MUL: begin
                acc_q    <= '0;
                mcand_q  <= PW'(opa_mag);
                mplier_q <= opb_mag;
                neg_q    <= req_i.opa[AW-1] ^ req_i.opb[AW-1];
                state_q  <= A_MUL;
              end
              slrf_pkg::OP_DIV: begin
                numsh_q <= req_i.frac32 ? {req_i.num, 32'b0} : {16'b0, req_i.num, 16'b0};
                den_q   <= req_i.den;
                rem_q   <= '0;
                quo_q   <= '0;
                sat_q   <= 1'b0;
                rnd_q   <= req_i.rnd;
                state_q <= A_DIV;
              end
              slrf_pkg::OP_SQRT: begin
                v_q     <= req_i.opa;
                root_q  <= '0;
                bit_q   <= AW'(1) << (AW - 2);
                state_q <= A_SQRT;
              end
              default: state_q <= A_IDLE;
            endcase
          end
        end
        A_MUL: begin
          if (mplier_q[0]) begin
            acc_q <= acc_q + mcand_q;
          end
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          cnt_q    <= cnt_q + CW'(1);
          if (cnt_q == MUL_LAST) begin
            state_q <= A_FIN;
          end
        end
        A_DIV: begin
          rem_q   <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
          sat_q   <= sat_q | quo_q[AW-1];
          quo_q   <= {quo_q[AW-2:0], ge};
          numsh_q <= numsh_q << 1;
          cnt_q   <= cnt_q + CW'(1);
          if (cnt_q == DIV_LAST) begin
            state_q <= A_FIN;
          end
        end
        A_SQRT: begin
          if (sq_ge) begin
            v_q    <= v_q - sq_t;
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == SQRT_LAST) begin
            state_q <= A_FIN;
          end
        end
        A_FIN: begin
          res_q   <= fin_res;
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/slrf_back.sv
// Back end: sequences the fit of one column over slrf_arith and holds the result.
// Depends on slrf_pkg; reads column sums from slrf_fifo.
module slrf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [slrf_pkg::Q_W-1:0]      noise_variance_i,
  input  logic                          fifo_empty_i,
  input  slrf_pkg::sums_t               fifo_data_i,
  output logic                          fifo_pop_o,
  output slrf_pkg::arith_req_t          arith_req_o,
  input  slrf_pkg::arith_rsp_t          arith_rsp_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output slrf_pkg::fit_t                fit_o
);

  localparam int AW = slrf_pkg::ARG_W;
  localparam int PW = slrf_pkg::PROD_W;
  localparam int DW = slrf_pkg::DEN_W;
  localparam int QW = slrf_pkg::Q_W;
  localparam int NC = slrf_pkg::COUNT_W;

  typedef enum logic [4:0] {
    B_IDLE, B_NSXX, B_SXSX, B_NSXY, B_SXSY, B_NSYY, B_SYSY, B_CHECK,
    B_SLOPE, B_SYA, B_BSX, B_NA, B_ICPT, B_VSXX, B_ISE, B_ISQ,
    B_VN, B_SSE, B_SSQ, B_CA, B_BB, B_NN2, B_DEN, B_RSE, B_RSQ, B_OUT
  } state_e;

  state_e          state_q;
  logic            wait_q;
  slrf_pkg::sums_t sums_q;
  logic [AW-1:0]   a_q, b_q, c_q, q_q;
  logic [PW-1:0]   t_q, num_q;
  logic [DW-1:0]   den_q;
  slrf_pkg::fit_t  res_q, out_q;
  logic            out_valid_q;

  logic [AW-1:0] n_ext, nm2_ext, sx_ext, sy_ext, sxx_ext, sxy_ext, syy_ext, nv_ext;
  logic [PW-1:0] p, diff, b_mag, num_mag;
  logic          is_step, unfit, out_load;

  function automatic logic [QW-1:0] sat_q16(input logic [AW-1:0] q, input logic neg);
    logic [QW-1:0] r;
    if (neg) begin
      r = (q >= AW'(64'h8000_0000)) ? 32'h8000_0000 : -q[QW-1:0];
    end else begin
      r = (q > AW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[QW-1:0];
    end
    return r;
  endfunction

  assign n_ext   = AW'(sums_q.n);
  assign nm2_ext = AW'(sums_q.n - NC'(2));
  assign sx_ext  = {{(AW-slrf_pkg::SUM_X_W){sums_q.sx[slrf_pkg::SUM_X_W-1]}}, sums_q.sx};
  assign sy_ext  = {{(AW-slrf_pkg::SUM_X_W){sums_q.sy[slrf_pkg::SUM_X_W-1]}}, sums_q.sy};
  assign sxx_ext = AW'(sums_q.sxx);
  assign syy_ext = AW'(sums_q.syy);
  assign sxy_ext = {{(AW-slrf_pkg::SUM_XY_W){sums_q.sxy[slrf_pkg::SUM_XY_W-1]}}, sums_q.sxy};
  assign nv_ext  = AW'(noise_variance_i);
  assign p       = arith_rsp_i.res;
  assign diff    = t_q - p;
  assign b_mag   = b_q[AW-1] ? -{{(PW-AW){b_q[AW-1]}}, b_q} : PW'(b_q);
  assign num_mag = num_q[PW-1] ? -num_q : num_q;
  assign unfit   = (sums_q.n < NC'(3)) || a_q[AW-1] || (a_q == '0);
  assign is_step = (state_q != B_IDLE) && (state_q != B_CHECK) && (state_q != B_OUT);
  assign out_load = (state_q == B_OUT) && (!out_valid_q || pop_i);

  assign fifo_pop_o = (state_q == B_IDLE) && !fifo_empty_i;
  assign empty_o    = !out_valid_q;
  assign fit_o      = out_q;

  always_comb begin
    arith_req_o        = '0;
    arith_req_o.start  = is_step && !wait_q;
    arith_req_o.op     = slrf_pkg::OP_MUL;
    unique case (state_q)
      B_NSXX: begin arith_req_o.opa = n_ext;  arith_req_o.opb = sxx_ext; end
      B_SXSX: begin arith_req_o.opa = sx_ext; arith_req_o.opb = sx_ext;  end
      B_NSXY: begin arith_req_o.opa = n_ext;  arith_req_o.opb = sxy_ext; end
      B_SXSY: begin arith_req_o.opa = sx_ext; arith_req_o.opb = sy_ext;  end
      B_NSYY: begin arith_req_o.opa = n_ext;  arith_req_o.opb = syy_ext; end
      B_SYSY: begin arith_req_o.opa = sy_ext; arith_req_o.opb = sy_ext;  end
      B_SLOPE: begin
        arith_req_o.op  = slrf_pkg::OP_DIV;
        arith_req_o.rnd = 1'b1;
        arith_req_o.num = b_mag;
        arith_req_o.den = DW'(a_q);
      end
      B_SYA: begin arith_req_o.opa = sy_ext; arith_req_o.opb = a_q;    end
      B_BSX: begin arith_req_o.opa = b_q;    arith_req_o.opb = sx_ext; end
      B_NA:  begin arith_req_o.opa = n_ext;  arith_req_o.opb = a_q;    end
      B_ICPT: begin
        arith_req_o.op  = slrf_pkg::OP_DIV;
        arith_req_o.rnd = 1'b1;
        arith_req_o.num = num_mag;
        arith_req_o.den = den_q;
      end
      B_VSXX: begin arith_req_o.opa = nv_ext; arith_req_o.opb = sxx_ext; end
      B_ISE, B_SSE: begin
        arith_req_o.op  = slrf_pkg::OP_DIV;
        arith_req_o.num = num_q;
        arith_req_o.den = DW'(a_q);
      end
      B_ISQ, B_SSQ, B_RSQ: begin
        arith_req_o.op  = slrf_pkg::OP_SQRT;
        arith_req_o.opa = q_q;
      end
      B_VN:  begin arith_req_o.opa = nv_ext; arith_req_o.opb = n_ext;   end
      B_CA:  begin arith_req_o.opa = c_q;    arith_req_o.opb = a_q;     end
      B_BB:  begin arith_req_o.opa = b_q;    arith_req_o.opb = b_q;     end
      B_NN2: begin arith_req_o.opa = n_ext;  arith_req_o.opb = nm2_ext; end
      B_DEN: begin arith_req_o.opa = a_q;    arith_req_o.opb = t_q[AW-1:0]; end
      B_RSE: begin
        arith_req_o.op     = slrf_pkg::OP_DIV;
        arith_req_o.frac32 = 1'b1;
        arith_req_o.num    = num_q;
        arith_req_o.den    = den_q;
      end
      default: arith_req_o.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      wait_q      <= 1'b0;
      sums_q      <= '0;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      q_q         <= '0;
      t_q         <= '0;
      num_q       <= '0;
      den_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      if (is_step && !wait_q) begin
        wait_q <= 1'b1;
      end
      unique case (state_q)
        B_IDLE: begin
          if (!fifo_empty_i) begin
            sums_q  <= fifo_data_i;
            state_q <= B_NSXX;
          end
        end
        B_CHECK: begin
          res_q   <= '{intercept: '0, slope: '0, intercept_stderr: '0,
                       slope_stderr: '0, residual_sigma: '0, fit_valid: !unfit};
          state_q <= unfit ? B_OUT : B_SLOPE;
        end
        B_OUT: begin
          if (out_load) begin
            out_q   <= res_q;
            state_q <= B_IDLE;
          end
        end
        default: begin
          if (wait_q && arith_rsp_i.done) begin
            wait_q <= 1'b0;
            unique case (state_q)
              B_NSXX: begin t_q <= p;             state_q <= B_SXSX; end
              B_SXSX: begin a_q <= diff[AW-1:0];  state_q <= B_NSXY; end
              B_NSXY: begin t_q <= p;             state_q <= B_SXSY; end
              B_SXSY: begin b_q <= diff[AW-1:0];  state_q <= B_NSYY; end
              B_NSYY: begin t_q <= p;             state_q <= B_SYSY; end
              B_SYSY: begin c_q <= diff[AW-1:0];  state_q <= B_CHECK; end
              B_SLOPE: begin
                res_q.slope <= sat_q16(p[AW-1:0], b_q[AW-1]);
                state_q     <= B_SYA;
              end
              B_SYA: begin t_q <= p;              state_q <= B_BSX; end
              B_BSX: begin num_q <= diff;         state_q <= B_NA;  end
              B_NA:  begin den_q <= p[DW-1:0];    state_q <= B_ICPT; end
              B_ICPT: begin
                res_q.intercept <= sat_q16(p[AW-1:0], num_q[PW-1]);
                state_q         <= B_VSXX;
              end
              B_VSXX: begin num_q <= p;           state_q <= B_ISE; end
              B_ISE:  begin q_q <= p[AW-1:0];     state_q <= B_ISQ; end
              B_ISQ: begin
                res_q.intercept_stderr <= p[QW-1:0];
                state_q                <= B_VN;
              end
              B_VN:  begin num_q <= p;            state_q <= B_SSE; end
              B_SSE: begin q_q <= p[AW-1:0];      state_q <= B_SSQ; end
              B_SSQ: begin
                res_q.slope_stderr <= p[QW-1:0];
                state_q            <= B_CA;
              end
              B_CA: begin t_q <= p;               state_q <= B_BB; end
              B_BB: begin
                num_q   <= diff[PW-1] ? '0 : diff;
                state_q <= B_NN2;
              end
              B_NN2: begin t_q <= p;              state_q <= B_DEN; end
              B_DEN: begin den_q <= p[DW-1:0];    state_q <= B_RSE; end
              B_RSE: begin q_q <= p[AW-1:0];      state_q <= B_RSQ; end
              B_RSQ: begin
                res_q.residual_sigma <= p[QW-1:0];
                state_q              <= B_OUT;
              end
              default: state_q <= B_IDLE;
            endcase
          end
        end
      endcase
    end
  end

endmodule
